### rtl/shell_integer_literal_parser_assert.svh
// ------------------------------------------------------------------------
// shell integer literal parser assertion macros
// clocked check helpers, compiled out for synthesis
// ------------------------------------------------------------------------
`ifndef SHELL_INTEGER_LITERAL_PARSER_ASSERT_SVH
`define SHELL_INTEGER_LITERAL_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication on clk, quiet in reset
`define SILP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("silp check failed");

// next-cycle implication on clk, quiet in reset
`define SILP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("silp check failed");

`else

`define SILP_ASSERT_IMP(label, ante, cons)
`define SILP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/silp_pkg.sv
// ------------------------------------------------------------------------
// silp_pkg
// types and constants shared by the shell integer literal parser
// ------------------------------------------------------------------------
`default_nettype none

package silp_pkg;

  // parse phases
  typedef enum logic [1:0] {
    PH_NORMAL,
    PH_ZERO,
    PH_LONG,
    PH_FRAC
  } phase_t;

  // configuration register indexes
  localparam logic CFG_ISO   = 1'b0;
  localparam logic CFG_OCTAL = 1'b1;

  // characters of interest
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_LX   = 8'h78;
  localparam logic [7:0] CH_UU   = 8'h55;
  localparam logic [7:0] CH_LU   = 8'h75;
  localparam logic [7:0] CH_UL   = 8'h4C;
  localparam logic [7:0] CH_LL   = 8'h6C;

  // bases
  localparam logic [31:0] BASE_OCT = 32'd8;
  localparam logic [31:0] BASE_DEC = 32'd10;
  localparam logic [31:0] BASE_HEX = 32'd16;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic iso;
    logic octal;
  } cfg_t;

  // per-literal state; zero_prod and zero_prod10 hold acc*base and acc*10
  // taken when a leading zero is seen, ready for the zero to settle
  typedef struct packed {
    logic [63:0] acc;
    logic [31:0] base;
    logic        no_digit_yet;
    logic        unsigned_seen;
    logic        long_seen;
    phase_t      phase;
    logic [7:0]  pending;
    logic [7:0]  count;
    logic [63:0] zero_prod;
    logic [63:0] zero_prod10;
  } lit_state_t;

  typedef struct packed {
    logic [63:0] value;
    logic        status;
    logic [31:0] last_base;
    logic [7:0]  consumed_count;
  } result_t;

  localparam lit_state_t LIT_RESET = '{
    acc:           64'd0,
    base:          BASE_DEC,
    no_digit_yet:  1'b1,
    unsigned_seen: 1'b0,
    long_seen:     1'b0,
    phase:         PH_NORMAL,
    pending:       8'd0,
    count:         8'd0,
    zero_prod:     64'd0,
    zero_prod10:   64'd0
  };

endpackage

`default_nettype wire

### rtl/silp_char_if.sv
// ------------------------------------------------------------------------
// silp_char_if
// character channel: valid/ready with one character code
// ------------------------------------------------------------------------
`default_nettype none

interface silp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

### rtl/silp_result_if.sv
// ------------------------------------------------------------------------
// silp_result_if
// result channel: valid/ready with the parsed literal
// ------------------------------------------------------------------------
`default_nettype none

interface silp_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic               status;
  logic signed [31:0] last_base;
  logic        [7:0]  consumed_count;

  modport source (output valid, output value, output status, output last_base,
                  output consumed_count, input ready);
  modport sink   (input valid, input value, input status, input last_base,
                  input consumed_count, output ready);
endinterface

`default_nettype wire

### rtl/shell_integer_literal_parser.sv
// ------------------------------------------------------------------------
// shell_integer_literal_parser
// character-at-a-time shell integer literal parser with base prefixes
// ------------------------------------------------------------------------
// usage
//   chars carries one character code per transfer; NUL or any character
//   that cannot belong to a literal ends it, and so does a bad digit or
//   suffix. each literal gives one transfer on results: value, status
//   (1 for a bad number), the base in force and the characters consumed
//   cfg_write/cfg_index/cfg_data set iso_constants (index 0) and
//   octal_leading_zero (index 1); write them only while the block is idle
// timing
//   a character transfer lands in the input register; from there it runs
//   through the parse logic into the literal state and, for a terminator,
//   loads the result register, which drives results.valid. one character
//   per cycle is sustained while no terminator waits on a full result
//   register: the limit is the single multiply-accumulate (two 32x32
//   partial products) per character
// stalls
//   a waiting result does not block characters that give no result; only
//   a character that ends a literal waits in the input register until the
//   result register is free, and chars.ready then drops
// reset
//   rst (synchronous) empties both registers, clears the literal state and
//   sets iso_constants to 1 and octal_leading_zero to 0
// ------------------------------------------------------------------------
`default_nettype none

`include "shell_integer_literal_parser_assert.svh"

module shell_integer_literal_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  silp_char_if.sink          chars,
  silp_result_if.source      results,
  input  wire logic          cfg_write,
  input  wire logic          cfg_index,
  input  wire logic          cfg_data
);

  silp_pkg::cfg_t       cfg;
  silp_pkg::lit_state_t lit;
  silp_pkg::lit_state_t lit_next;
  silp_pkg::result_t    step_res;
  silp_pkg::result_t    out_res;
  logic                 emit;
  logic                 in_vld;
  logic [7:0]           in_char;
  logic                 out_vld;
  logic                 out_free;
  logic                 adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.iso   <= 1'b1;
      cfg.octal <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        silp_pkg::CFG_ISO:   cfg.iso   <= cfg_data;
        silp_pkg::CFG_OCTAL: cfg.octal <= cfg_data;
        default:             cfg.iso   <= cfg.iso;
      endcase
    end
  end

  // the held character moves on unless it ends a literal and the result
  // register is still full
  assign out_free    = !out_vld || results.ready;
  assign adv         = in_vld && (!emit || out_free);
  assign chars.ready = !in_vld || adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (chars.ready) begin
      in_vld <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_char <= chars.char_code;
    end
  end

  silp_step u_step (
    .lit       (lit),
    .char_code (in_char),
    .cfg       (cfg),
    .lit_next  (lit_next),
    .emit      (emit),
    .res       (step_res)
  );

  // literal state
  always_ff @(posedge clk) begin
    if (rst) begin
      lit <= silp_pkg::LIT_RESET;
    end else if (adv) begin
      lit <= lit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && emit) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_res <= step_res;
    end
  end

  assign results.valid          = out_vld;
  assign results.value          = out_res.value;
  assign results.status         = out_res.status;
  assign results.last_base      = out_res.last_base;
  assign results.consumed_count = out_res.consumed_count;

  // checks
  `SILP_ASSERT_IMP(a_zero_after_digit, lit.phase == silp_pkg::PH_ZERO, !lit.no_digit_yet)
  `SILP_ASSERT_IMP(a_long_has_flag, lit.phase == silp_pkg::PH_LONG, lit.long_seen)
  `SILP_ASSERT_NEXT(a_clear_after_result, adv && emit, (lit.phase == silp_pkg::PH_NORMAL) && (lit.count == 8'd0) && lit.no_digit_yet)
  `SILP_ASSERT_IMP(a_hold_only_on_full, in_vld && !adv, emit && out_vld && !results.ready)

endmodule

`default_nettype wire

### rtl/silp_mac.sv
// ------------------------------------------------------------------------
// silp_mac
// base * acc + digit modulo 2^64, from two 32x32 partial products
// ------------------------------------------------------------------------
`default_nettype none

module silp_mac (
  input  wire logic [31:0] base,
  input  wire logic [63:0] acc,
  input  wire logic [5:0]  digit,
  output logic      [63:0] sum
);

  logic [63:0] prod_lo;
  logic [31:0] prod_hi;

  // base is positive whenever the product is used, so it needs no sign fix
  assign prod_lo = {32'd0, base} * {32'd0, acc[31:0]};
  assign prod_hi = base * acc[63:32];
  assign sum     = prod_lo + {prod_hi, 32'd0} + {58'd0, digit};

endmodule

`default_nettype wire

### rtl/silp_step.sv
// ------------------------------------------------------------------------
// silp_step
// next literal state and result for one character
// ------------------------------------------------------------------------
`default_nettype none

module silp_step (
  input  wire silp_pkg::lit_state_t lit,
  input  wire logic [7:0]           char_code,
  input  wire silp_pkg::cfg_t       cfg,
  output silp_pkg::lit_state_t      lit_next,
  output logic                      emit,
  output silp_pkg::result_t         res
);

  silp_pkg::lit_state_t upd;
  logic        status;
  logic        is_dig;
  logic        is_upper;
  logic        is_lower;
  logic        is_alnum;
  logic        is_x;
  logic [5:0]  digit;
  logic [7:0]  cnt_inc;
  logic [31:0] base_z;
  logic [63:0] acc_z;
  logic        settle_ok;
  logic        run_pc;
  logic [63:0] pc_acc;
  logic [31:0] pc_base;
  logic        suffix_base;
  logic [63:0] mac_sum;

  // character classes
  always_comb begin
    is_dig   = (char_code >= silp_pkg::CH_0) && (char_code <= silp_pkg::CH_9);
    is_upper = (char_code >= silp_pkg::CH_UA) && (char_code <= silp_pkg::CH_UZ);
    is_lower = (char_code >= silp_pkg::CH_LA) && (char_code <= silp_pkg::CH_LZ);
    is_alnum = is_dig || is_upper || is_lower;
    is_x     = (char_code == silp_pkg::CH_LX) || (char_code == silp_pkg::CH_UX);
    if (is_dig) begin
      digit = 6'(char_code - silp_pkg::CH_0);
    end else if (is_upper) begin
      digit = 6'(char_code - silp_pkg::CH_UA) + 6'd10;
    end else if (is_lower) begin
      digit = 6'(char_code - silp_pkg::CH_LA) + 6'd10;
    end else begin
      digit = 6'd0;
    end
    cnt_inc = (lit.count == silp_pkg::COUNT_MAX) ? lit.count : lit.count + 8'd1;
  end

  // leading zero: base chosen by the character after it, product by selection
  always_comb begin
    if (is_x) begin
      base_z = silp_pkg::BASE_HEX;
      acc_z  = {lit.acc[59:0], 4'd0};
    end else if (cfg.octal) begin
      base_z = is_dig ? silp_pkg::BASE_OCT : silp_pkg::BASE_DEC;
      acc_z  = is_dig ? {lit.acc[60:0], 3'd0} : lit.zero_prod10;
    end else begin
      base_z = lit.base;
      acc_z  = lit.zero_prod;
    end
    settle_ok = !(lit.unsigned_seen || lit.long_seen) && ($signed(base_z) > 32'sd0);
  end

  assign suffix_base = (pc_base == silp_pkg::BASE_OCT) || (pc_base == silp_pkg::BASE_DEC) ||
                       (pc_base == silp_pkg::BASE_HEX);

  silp_mac u_mac (
    .base  (pc_base),
    .acc   (pc_acc),
    .digit (digit),
    .sum   (mac_sum)
  );

  // next state
  always_comb begin
    upd     = lit;
    emit    = 1'b0;
    status  = 1'b0;
    run_pc  = 1'b0;
    pc_acc  = lit.acc;
    pc_base = lit.base;

    case (lit.phase)
      silp_pkg::PH_FRAC: begin
        if (is_dig) begin
          upd.count = cnt_inc;
        end else begin
          emit = 1'b1;
        end
      end
      silp_pkg::PH_LONG: begin
        upd.phase = silp_pkg::PH_NORMAL;
        if (char_code == lit.pending) begin
          upd.count = cnt_inc;
        end else begin
          run_pc = 1'b1;
        end
      end
      silp_pkg::PH_ZERO: begin
        upd.phase = silp_pkg::PH_NORMAL;
        upd.base  = base_z;
        if (is_x) begin
          upd.count = cnt_inc;
          if (settle_ok) begin
            upd.acc = acc_z;
          end else begin
            emit   = 1'b1;
            status = 1'b1;
          end
        end else if (!settle_ok) begin
          emit   = 1'b1;
          status = 1'b1;
        end else begin
          run_pc  = 1'b1;
          pc_acc  = acc_z;
          pc_base = base_z;
        end
      end
      default: begin
        run_pc = 1'b1;
      end
    endcase

    if (run_pc) begin
      upd.acc  = pc_acc;
      upd.base = pc_base;
      if (char_code == silp_pkg::CH_NUL) begin
        emit = 1'b1;
      end else if (char_code == silp_pkg::CH_HASH) begin
        upd.base  = pc_acc[31:0];
        upd.acc   = 64'd0;
        upd.count = cnt_inc;
      end else if (char_code == silp_pkg::CH_DOT) begin
        upd.count = cnt_inc;
        if (pc_base != silp_pkg::BASE_DEC) begin
          emit   = 1'b1;
          status = 1'b1;
        end else begin
          upd.phase = silp_pkg::PH_FRAC;
        end
      end else if (cfg.iso && suffix_base &&
                   ((char_code == silp_pkg::CH_LU) || (char_code == silp_pkg::CH_UU))) begin
        upd.count = cnt_inc;
        if (lit.unsigned_seen) begin
          emit   = 1'b1;
          status = 1'b1;
        end else begin
          upd.unsigned_seen = 1'b1;
        end
      end else if (cfg.iso && suffix_base &&
                   ((char_code == silp_pkg::CH_LL) || (char_code == silp_pkg::CH_UL))) begin
        upd.count = cnt_inc;
        if (lit.long_seen) begin
          emit   = 1'b1;
          status = 1'b1;
        end else begin
          upd.long_seen = 1'b1;
          upd.pending   = char_code;
          upd.phase     = silp_pkg::PH_LONG;
        end
      end else if (!is_alnum) begin
        emit = 1'b1;
      end else begin
        upd.count = cnt_inc;
        if (cfg.iso && (char_code == silp_pkg::CH_0) && lit.no_digit_yet) begin
          // hold the zero until the next character decides the base
          upd.no_digit_yet = 1'b0;
          upd.phase        = silp_pkg::PH_ZERO;
          upd.zero_prod    = mac_sum;
          upd.zero_prod10  = {pc_acc[60:0], 3'd0} + {pc_acc[62:0], 1'b0};
        end else begin
          if (cfg.iso && is_dig) begin
            upd.no_digit_yet = 1'b0;
          end
          if (cfg.iso && (lit.unsigned_seen || lit.long_seen)) begin
            emit   = 1'b1;
            status = 1'b1;
          end else if ($signed({26'd0, digit}) >= $signed(pc_base)) begin
            emit   = 1'b1;
            status = 1'b1;
          end else begin
            upd.acc = mac_sum;
          end
        end
      end
    end
  end

  // outputs
  always_comb begin
    lit_next           = emit ? silp_pkg::LIT_RESET : upd;
    res.value          = upd.acc;
    res.status         = status;
    res.last_base      = upd.base;
    res.consumed_count = upd.count;
  end

endmodule

`default_nettype wire
